// ===== sv/swse_pkg.sv =====
// ----------------------------------------------------------------------------
// swse_pkg: shared definitions for the sliding window slope estimator
// Field widths, default sizes, the gain reset value and the pipeline
// control word passed between the stages.
// ----------------------------------------------------------------------------
package swse_pkg;

  localparam int WINDOW_DEF   = 10;
  localparam int CHANNELS_DEF = 12;

  localparam int CHAN_W    = 4;
  localparam int SAMPLE_W  = 16;
  localparam int SLOPE_W   = 24;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 16;

  // Stream word layouts.
  localparam int IN_DATA_W  = 24;
  localparam int IN_PAD_W   = IN_DATA_W - CHAN_W - SAMPLE_W;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - CHAN_W - SLOPE_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd3972;

  // Control word that travels with each item down the pipeline.
  typedef struct packed {
    logic              valid;
    logic              in_range;
    logic [CHAN_W-1:0] channel;
  } pipe_ctl_t;

endpackage

// ===== sv/swse_row_ram.sv =====
// ----------------------------------------------------------------------------
// swse_row_ram: per-channel state memory
// One row per channel, one write and one read port, registered read data.
// Per-row valid flags mark rows never written; rd_valid reads low for them.
// ----------------------------------------------------------------------------
module swse_row_ram #(
  parameter int DEPTH = 12,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  output logic             rd_valid,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

endmodule

// ===== sv/swse_update.sv =====
// ----------------------------------------------------------------------------
// swse_update: window row update
// Shifts the new sample into a channel row and updates the running total
// and the weighted sum recursively from the sample that drops out.
// ----------------------------------------------------------------------------
module swse_update #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 23,
  parameter int TOT_W  = 20,
  parameter int ROW_W  = 203
) (
  input  logic                                 rd_valid,
  input  logic [ROW_W-1:0]                     row_rd,
  input  logic                                 fwd_hit,
  input  logic [ROW_W-1:0]                     fwd_row,
  input  logic signed [swse_pkg::SAMPLE_W-1:0] sample,
  output logic [ROW_W-1:0]                     row_new,
  output logic signed [SUM_W-1:0]              sum_new
);
  import swse_pkg::*;

  localparam int WIN_BITS = SAMPLE_W * WINDOW;
  localparam logic signed [SUM_W-1:0] K_OLD = SUM_W'(WINDOW + 1);
  localparam logic signed [SUM_W-1:0] K_NEW = SUM_W'(WINDOW - 1);

  logic [ROW_W-1:0]          row_cur;
  logic [WIN_BITS-1:0]       win_old;
  logic [WIN_BITS-1:0]       win_new;
  logic signed [SAMPLE_W-1:0] oldest;
  logic signed [TOT_W-1:0]   tot_old;
  logic signed [TOT_W-1:0]   tot_new;
  logic signed [SUM_W-1:0]   sum_old;

  // The row written in the previous cycle has not reached the read data yet.
  assign row_cur = fwd_hit ? fwd_row : (rd_valid ? row_rd : '0);

  assign win_old = row_cur[WIN_BITS-1:0];
  assign tot_old = $signed(row_cur[WIN_BITS +: TOT_W]);
  assign sum_old = $signed(row_cur[WIN_BITS + TOT_W +: SUM_W]);
  assign oldest  = $signed(win_old[SAMPLE_W-1:0]);

  always_comb begin
    for (int k = 0; k < WINDOW - 1; k++) begin
      win_new[SAMPLE_W*k +: SAMPLE_W] = win_old[SAMPLE_W*(k+1) +: SAMPLE_W];
    end
    win_new[SAMPLE_W*(WINDOW-1) +: SAMPLE_W] = sample;
  end

  // S' = S + (N+1)*oldest - 2*T + (N-1)*new, with T the total before the shift.
  assign sum_new = sum_old + K_OLD * SUM_W'(oldest) - (SUM_W'(tot_old) <<< 1)
                 + K_NEW * SUM_W'(sample);
  assign tot_new = tot_old - TOT_W'(oldest) + TOT_W'(sample);

  assign row_new = {sum_new, tot_new, win_new};

endmodule

// ===== sv/swse_scale.sv =====
// ----------------------------------------------------------------------------
// swse_scale: gain, rounding and saturation
// Multiplies the weighted sum by the gain, rounds to nearest and clips to the
// slope range (zero if out of range); the last stage is the output register.
// ----------------------------------------------------------------------------
module swse_scale #(
  parameter int SUM_W = 23
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  swse_pkg::pipe_ctl_t                 in_ctl,
  input  logic signed [SUM_W-1:0]             in_sum,
  input  logic [swse_pkg::GAIN_W-1:0]         gain,
  output logic                                out_valid,
  output logic [swse_pkg::CHAN_W-1:0]         out_channel,
  output logic signed [swse_pkg::SLOPE_W-1:0] slope,
  output logic                                saturated
);
  import swse_pkg::*;

  localparam int PW = SUM_W + GAIN_W + 1;
  localparam int RW = PW + 1;
  localparam int QW = RW - GAIN_FRAC;
  localparam int EW = (QW > SLOPE_W) ? QW : SLOPE_W + 1;

  localparam logic signed [RW-1:0] HALF    = RW'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [EW-1:0] LIM_MAX = EW'(2 ** (SLOPE_W - 1) - 1);
  localparam logic signed [EW-1:0] LIM_MIN = ~LIM_MAX;

  pipe_ctl_t             p_ctl;
  logic signed [PW-1:0]  prod;
  logic signed [RW-1:0]  rnd;
  logic signed [QW-1:0]  quo;
  logic signed [EW-1:0]  quo_ext;
  logic                  over;
  logic                  under;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl.valid <= 1'b0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      p_ctl.valid <= in_ctl.valid;
      out_valid   <= p_ctl.valid;
    end
    if (adv) begin
      p_ctl.in_range <= in_ctl.in_range;
      p_ctl.channel  <= in_ctl.channel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= in_sum * $signed({1'b0, gain});
    end
  end

  // Floor of (P + half) / 2^16 is an arithmetic shift of the rounded sum.
  assign rnd     = RW'(prod) + HALF;
  assign quo     = $signed(rnd[RW-1:GAIN_FRAC]);
  assign quo_ext = EW'(quo);
  assign over    = quo_ext > LIM_MAX;
  assign under   = quo_ext < LIM_MIN;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_channel <= p_ctl.channel;
      if (!p_ctl.in_range) begin
        slope     <= '0;
        saturated <= 1'b0;
      end else if (over) begin
        slope     <= LIM_MAX[SLOPE_W-1:0];
        saturated <= 1'b1;
      end else if (under) begin
        slope     <= LIM_MIN[SLOPE_W-1:0];
        saturated <= 1'b1;
      end else begin
        slope     <= quo_ext[SLOPE_W-1:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/sliding_window_slope_estimator_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_slope_estimator_core: per-channel least-squares slope
// Keeps the last WINDOW samples per channel and reports the scaled, saturated
// least-squares slope of that window for every sample, zero if out of range.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word contents (lowest bit first)
//   s_*       in         tdata: channel[3:0], sample[19:4], zero pad[23:20]
//   m_*       out        tdata: out_channel[3:0], slope[27:4], zero pad[31:28]
//                        tuser: saturated
//   cfg_*     in         cfg_data: slope_gain, written when cfg_we is high
//
// One word is taken per clock cycle unless m_tready stalls the output. The row
// read is issued at the edge that accepts the word; then come the row update
// and write-back, the gain multiply, and rounding and saturation into the
// output register, each at its own registered stage.
// The pace is set by the read-modify-write of a channel row; a row written
// in the previous cycle is forwarded around the memory.
// Reset clears the row valid flags, so no clearing pass is needed. A stall
// on m_tready holds the whole pipeline and drops s_tready.
//
// Each memory row holds the channel's window, the plain total of the window
// and the weighted sum, so a new sum needs only the sample that drops out.
module sliding_window_slope_estimator_core #(
  parameter int WINDOW   = swse_pkg::WINDOW_DEF,
  parameter int CHANNELS = swse_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port for slope_gain.
  input  logic                              cfg_we,
  input  logic [swse_pkg::GAIN_W-1:0]       cfg_data,
  // Input stream: channel in [3:0], sample in [19:4].
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [swse_pkg::IN_DATA_W-1:0]    s_tdata,
  // Output stream: out_channel in [3:0], slope in [27:4].
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [swse_pkg::OUT_DATA_W-1:0]   m_tdata,
  // Output flag: saturated.
  output logic                              m_tuser
);
  import swse_pkg::*;

  // Weighted sum and window total widths; weights run from -(N-1) to N-1.
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW * WINDOW);
  localparam int TOT_W = SAMPLE_W + $clog2(WINDOW);
  localparam int ROW_W = SAMPLE_W * WINDOW + TOT_W + SUM_W;
  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [GAIN_W-1:0]          slope_gain;
  logic                       adv;
  logic                       accept;
  logic [CHAN_W-1:0]          in_channel;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_range;

  pipe_ctl_t                  s1_ctl;
  logic signed [SAMPLE_W-1:0] s1_sample;
  pipe_ctl_t                  s2_ctl;
  logic signed [SUM_W-1:0]    s2_sum;

  logic [ROW_W-1:0]           rd_row;
  logic                       rd_valid;
  logic                       wr_en;
  logic [ROW_W-1:0]           row_new;
  logic signed [SUM_W-1:0]    sum_new;

  logic                       fwd_valid;
  logic [CHAN_W-1:0]          fwd_ch;
  logic [ROW_W-1:0]           fwd_row;
  logic                       fwd_hit;

  logic [CHAN_W-1:0]          out_channel;
  logic signed [SLOPE_W-1:0]  slope;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      slope_gain <= cfg_data;
    end
  end

  // The pipeline moves whenever the output register is empty or drained.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  assign in_channel = s_tdata[CHAN_W-1:0];
  assign in_sample  = $signed(s_tdata[CHAN_W +: SAMPLE_W]);
  assign in_range   = 32'(in_channel) < 32'(CHANNELS);

  // Stage 1: the row read is issued at the accepting edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else if (adv) begin
      s1_ctl.valid <= accept;
    end
    if (adv) begin
      s1_ctl.in_range <= in_range;
      s1_ctl.channel  <= in_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample <= in_sample;
    end
  end

  swse_row_ram #(
    .DEPTH (CHANNELS),
    .WIDTH (ROW_W),
    .AW    (AW)
  ) u_row_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && in_range),
    .rd_addr  (AW'(in_channel)),
    .rd_data  (rd_row),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (AW'(s1_ctl.channel)),
    .wr_data  (row_new)
  );

  // The forward register mirrors the last row written, so a word for the
  // same channel right behind it sees the update the memory read missed.
  assign fwd_hit = fwd_valid && (fwd_ch == s1_ctl.channel);

  swse_update #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .TOT_W  (TOT_W),
    .ROW_W  (ROW_W)
  ) u_update (
    .rd_valid (rd_valid),
    .row_rd   (rd_row),
    .fwd_hit  (fwd_hit),
    .fwd_row  (fwd_row),
    .sample   (s1_sample),
    .row_new  (row_new),
    .sum_new  (sum_new)
  );

  // Out-of-range channels leave every row untouched.
  assign wr_en = adv && s1_ctl.valid && s1_ctl.in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_ch  <= s1_ctl.channel;
      fwd_row <= row_new;
    end
  end

  // Stage 2: registered weighted sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else if (adv) begin
      s2_ctl.valid <= s1_ctl.valid;
    end
    if (adv) begin
      s2_ctl.in_range <= s1_ctl.in_range;
      s2_ctl.channel  <= s1_ctl.channel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum <= sum_new;
    end
  end

  // Stages 3 and 4: gain multiply, then rounding and clipping.
  swse_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_ctl      (s2_ctl),
    .in_sum      (s2_sum),
    .gain        (slope_gain),
    .out_valid   (m_tvalid),
    .out_channel (out_channel),
    .slope       (slope),
    .saturated   (m_tuser)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, slope, out_channel};

endmodule

// ===== test/tb_sliding_window_slope_estimator_core.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_slope_estimator_core: self-checking bench for the core
// Streams channel/sample words into the estimator, predicts every slope
// from a private copy of the per-channel windows and the gain, and compares
// each output word field by field under changing gains and flow control.
// ----------------------------------------------------------------------------
module tb_sliding_window_slope_estimator_core;

  import swse_pkg::*;

  localparam int NUM_WINDOW   = WINDOW_DEF;
  localparam int NUM_CHANNELS = CHANNELS_DEF;

  // Output range of the slope field.
  localparam longint SLOPE_TOP = 64'sd8388607;
  localparam longint SLOPE_BOT = -64'sd8388608;

  // Run control. The limit is far above the slowest legal run, which is
  // about a thousand words plus one long hold-off.
  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int END_SETTLE    = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_WORDS  = 200;
  localparam int BURST_WORDS   = 40;

  // Block ports. Every input has a known value from time zero.
  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  cfg_we   = 1'b0;
  logic [GAIN_W-1:0]     cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // Fields from bit 0 up: channel[3:0], sample[19:4], zero pad[23:20].
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // Fields from bit 0 up: out_channel[3:0], slope[27:4], zero pad[31:28].
  logic [OUT_DATA_W-1:0] m_tdata;
  // Fields from bit 0 up: saturated.
  logic                  m_tuser;

  // One predicted output word.
  typedef struct packed {
    logic [CHAN_W-1:0]         channel;
    logic signed [SLOPE_W-1:0] slope;
    logic                      saturated;
  } slope_word_t;

  // Private copy of the block state: the windows (index 0 is the oldest
  // sample) and the gain currently in force.
  logic signed [SAMPLE_W-1:0] chan_window [NUM_CHANNELS][NUM_WINDOW];
  logic [GAIN_W-1:0]          gain_now;

  // Slopes predicted for accepted words, oldest first.
  slope_word_t pending_slopes [$];

  // Flow control knobs. The sender percentage is only read by the main
  // process; the receiver percentage is changed with nonblocking writes
  // because the receiver process samples it at the clock edge.
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  logic hold_start    = 1'b0;
  int   hold_left     = 0;

  int   cycle_count   = 0;
  int   words_sent    = 0;
  int   words_checked = 0;
  int   mismatches    = 0;
  int   gain_writes   = 0;

  sliding_window_slope_estimator_core #(
    .WINDOW   (NUM_WINDOW),
    .CHANNELS (NUM_CHANNELS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shift a sample into its channel window and work out the slope word the
  // block must produce. A channel beyond the last one leaves every window
  // alone and reports a zero slope.
  function automatic slope_word_t predict_slope(input logic [CHAN_W-1:0] ch,
                                                input logic [SAMPLE_W-1:0] smp);
    slope_word_t res;
    longint      wsum;
    longint      scaled;
    begin
      res.channel   = ch;
      res.slope     = '0;
      res.saturated = 1'b0;
      if (ch < NUM_CHANNELS) begin
        for (int k = 0; k < NUM_WINDOW - 1; k++)
          chan_window[ch][k] = chan_window[ch][k+1];
        chan_window[ch][NUM_WINDOW-1] = $signed(smp);
        // Centred time weights 2k-(N-1) make the least-squares slope a
        // plain weighted sum of the window.
        wsum = 0;
        for (int k = 0; k < NUM_WINDOW; k++)
          wsum += longint'(2 * k - (NUM_WINDOW - 1)) * longint'(chan_window[ch][k]);
        // Round to nearest, ties upward: add half an LSB, then floor.
        scaled = (wsum * longint'({1'b0, gain_now}) + 64'sd32768) >>> GAIN_FRAC;
        if (scaled > SLOPE_TOP) begin
          scaled        = SLOPE_TOP;
          res.saturated = 1'b1;
        end else if (scaled < SLOPE_BOT) begin
          scaled        = SLOPE_BOT;
          res.saturated = 1'b1;
        end
        res.slope = scaled[SLOPE_W-1:0];
      end
      return res;
    end
  endfunction

  // Most random words go to real channels; the rest exercise the channel
  // numbers that have no window.
  function automatic logic [CHAN_W-1:0] pick_channel();
    if ($urandom_range(99) < 90)
      return CHAN_W'($urandom_range(NUM_CHANNELS - 1));
    return CHAN_W'($urandom_range(15, NUM_CHANNELS));
  endfunction

  // Samples are a mix of full-range noise, rail values and small values
  // near zero, so that both large and fine slopes show up.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0, 1: return SAMPLE_W'($urandom);
      2: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return SAMPLE_W'($urandom_range(127)) - 16'd64;
    endcase
  endfunction

  // Offer one word, after a random idle gap when the sender is set to idle.
  // The valid stays high afterwards so back-to-back words need no toggle.
  task automatic send_word(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    int gap;
    begin
      gap = 0;
      while (gap < 20 && $urandom_range(99) < src_idle_pct)
        gap++;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= {{IN_PAD_W{1'b0}}, smp, ch};
      do @(posedge clk); while (!s_tready);
      pending_slopes.push_back(predict_slope(ch, smp));
      words_sent++;
    end
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_slopes.size() != 0)
      @(posedge clk);
  endtask

  // Write the gain register. Only called with the pipeline empty.
  task automatic write_gain(input logic [GAIN_W-1:0] gain);
    cfg_we   <= 1'b1;
    cfg_data <= gain;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gain_now  = gain;
    gain_writes++;
  endtask

  // Directed words at the reset gain: rail samples, the topmost channel,
  // channels with no window, and a step from the negative rail to the
  // positive one that gives the largest weighted sum. The first words of
  // each channel it uses also check that unwritten entries count as zero.
  task automatic test_reset_gain();
    send_word(4'd0, 16'h7FFF);
    send_word(4'd0, 16'h8000);
    send_word(4'd11, 16'hFFFF);
    send_word(4'd11, 16'h0001);
    send_word(4'd12, 16'h7FFF);
    send_word(4'd15, 16'h8000);
    for (int k = 0; k < NUM_WINDOW; k++)
      send_word(4'd3, (k < NUM_WINDOW / 2) ? 16'h8000 : 16'h7FFF);
    wait_for_results();
  endtask

  // Gain corners: zero, full scale, and one half, which turns an odd
  // weighted sum into an exact rounding tie.
  task automatic test_gain_corners();
    write_gain(16'd0);
    send_word(4'd3, 16'h7FFF);
    send_word(4'd13, 16'hFFFF);
    wait_for_results();
    write_gain(16'hFFFF);
    send_word(4'd5, 16'h7FFF);
    send_word(4'd5, 16'h8000);
    send_word(4'd3, 16'h7FFF);
    wait_for_results();
    write_gain(16'h8000);
    send_word(4'd1, 16'h0001);
    send_word(4'd1, 16'hFFFF);
    wait_for_results();
  endtask

  // One phase of random traffic with a given gain and flow control mix.
  task automatic test_random_traffic(input logic [GAIN_W-1:0] gain, input int src_pct,
                                     input int snk_pct);
    write_gain(gain);
    src_idle_pct   = src_pct;
    snk_stall_pct <= snk_pct;
    repeat (RANDOM_WORDS)
      send_word(pick_channel(), pick_sample());
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words, so the pipeline fills and the input must stall.
  task automatic test_backpressure();
    write_gain(GAIN_W'($urandom));
    src_idle_pct   = 0;
    snk_stall_pct <= 0;
    hold_start    <= 1'b1;
    @(posedge clk);
    hold_start    <= 1'b0;
    repeat (BURST_WORDS)
      send_word(pick_channel(), pick_sample());
    wait_for_results();
  endtask

  // Receiver: a long hold-off when asked, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_start)
      hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Compare every accepted output word with the oldest prediction.
  always @(posedge clk) begin
    slope_word_t want;
    slope_word_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.channel   = m_tdata[CHAN_W-1:0];
      got.slope     = m_tdata[CHAN_W +: SLOPE_W];
      got.saturated = m_tuser;
      if (pending_slopes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected word ch=%0d slope=%0d sat=%0b",
                   got.channel, got.slope, got.saturated);
      end else begin
        want = pending_slopes.pop_front();
        words_checked++;
        if (got.channel !== want.channel || got.slope !== want.slope ||
            got.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: word %0d expected ch=%0d slope=%0d sat=%0b, got ch=%0d slope=%0d sat=%0b",
                     words_checked, want.channel, want.slope, want.saturated,
                     got.channel, got.slope, got.saturated);
        end
      end
    end
  end

  // Watchdog: a run that overstays the cycle budget has hung.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    foreach (chan_window[c, k])
      chan_window[c][k] = '0;
    gain_now = GAIN_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_gain();
    test_gain_corners();
    test_backpressure();
    test_random_traffic(GAIN_W'($urandom), 0, 0);
    test_random_traffic(GAIN_RESET, 53, 0);
    test_random_traffic(16'hFFFF, 0, 53);
    test_random_traffic(GAIN_W'($urandom), 17, 17);

    // Let any stray word appear before the verdict.
    repeat (END_SETTLE) @(posedge clk);
    if (pending_slopes.size() != 0)
      mismatches++;

    $display("Sent %0d words over %0d channel windows, checked %0d slopes, %0d gain writes.",
             words_sent, NUM_CHANNELS, words_checked, gain_writes);
    $display("Covered rail samples, unused channels, rounding ties, idle and stall mixes, %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
